>>> hdl/mrta_pkg.sv
// ----------------------------------------------------------------------------
// mrta_pkg
// Shared widths, codes and controller/datapath interface types for the
// mesh route table with aging.
// ----------------------------------------------------------------------------
package mrta_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   localparam int OP_W      = 3;
   localparam int MAC_W     = 48;
   localparam int HOPS_W    = 8;
   localparam int MS_W      = 32;
   localparam int OUTCOME_W = 3;
   localparam int REMOVED_W = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 48;

   localparam logic [OP_W-1:0] OP_LEARN  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
   localparam logic [OP_W-1:0] OP_FORGET = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_EXPIRE = 3'd4;

   localparam logic [OUTCOME_W-1:0] OUT_NONE      = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_REFRESHED = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_INSERTED  = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_OWN       = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_LIMIT = 1'd1;

   localparam logic [MS_W-1:0] STALE_LIMIT_RESET = 32'd60000;

   typedef struct packed {
      logic load_req;
      logic scan_start;
      logic rd_en;
      logic write_en;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic is_learn;
      logic scan_last;
      logic rsp_free;
   } status_type;

endpackage

>>> hdl/mrta_ctrl.sv
// ----------------------------------------------------------------------------
// mrta_ctrl
// Sequencer for one request: check, table scan, optional learn write and
// result hand-off.
// ----------------------------------------------------------------------------
module mrta_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mrta_pkg::status_type   status,
   output mrta_pkg::cmd_type      cmd
);
   import mrta_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_WRITE  = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.skip ? ST_RESULT : ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = status.is_learn ? ST_WRITE : ST_RESULT;
         end
         ST_WRITE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load_req   = (state_ff == ST_IDLE) && req_valid;
      cmd.scan_start = (state_ff == ST_CHECK);
      cmd.rd_en      = (state_ff == ST_SCAN);
      cmd.write_en   = (state_ff == ST_WRITE);
      cmd.load_rsp   = (state_ff == ST_RESULT) && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/mrta_dp.sv
// ----------------------------------------------------------------------------
// mrta_dp
// Route table storage, one-entry-per-cycle scan and compare, learn update,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module mrta_dp #(
   parameter int TABLE_ENTRIES = mrta_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mrta_pkg::cmd_type                cmd,
   output mrta_pkg::status_type             status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mrta_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mrta_pkg::CSR_DAT_W-1:0]   csr_wdata,
   input  logic [mrta_pkg::OP_W-1:0]        req_operation,
   input  logic [mrta_pkg::MAC_W-1:0]       req_key_mac,
   input  logic [mrta_pkg::MAC_W-1:0]       req_neighbor_mac,
   input  logic [mrta_pkg::HOPS_W-1:0]      req_hop_count,
   input  logic [mrta_pkg::MS_W-1:0]        req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [mrta_pkg::MAC_W-1:0]       rsp_next_hop_mac,
   output logic [mrta_pkg::OUTCOME_W-1:0]   rsp_learn_outcome,
   output logic [mrta_pkg::REMOVED_W-1:0]   rsp_removed_count
);
   import mrta_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // configuration
   logic [MAC_W-1:0] own_ff;
   logic [MS_W-1:0]  limit_ff;

   // latched request
   logic [OP_W-1:0]   op_ff;
   logic [MAC_W-1:0]  key_ff;
   logic [MAC_W-1:0]  nbr_ff;
   logic [HOPS_W-1:0] hops_ff;
   logic [MS_W-1:0]   now_ff;

   // table
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [MAC_W-1:0]  dest_mem  [TABLE_ENTRIES];
   logic [MAC_W-1:0]  nhop_mem  [TABLE_ENTRIES];
   logic [HOPS_W-1:0] hops_mem  [TABLE_ENTRIES];
   logic [MS_W-1:0]   stamp_mem [TABLE_ENTRIES];

   // scan pipeline
   logic [IDX_W-1:0]  addr_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_vld_ff;
   logic [MAC_W-1:0]  rd_dest_ff;
   logic [MAC_W-1:0]  rd_nhop_ff;
   logic [HOPS_W-1:0] rd_hops_ff;
   logic [MS_W-1:0]   rd_stamp_ff;

   // scan results
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [HOPS_W-1:0] hit_hops_ff;
   logic [MAC_W-1:0]  hit_nhop_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic [REMOVED_W-1:0] removed_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [MAC_W-1:0]     rsp_nhop_ff;
   logic [OUTCOME_W-1:0] rsp_outcome_ff;
   logic [REMOVED_W-1:0] rsp_removed_ff;

   logic              own_match;
   logic              op_known;
   logic              cur_valid;
   logic              key_match;
   logic [MS_W-1:0]   age;
   logic              stale;
   logic              drop;
   logic [IDX_W-1:0]  wr_idx;
   logic              wr_entry;
   logic              wr_route;
   logic              wr_stamp;

   assign csr_ready = 1'b1;

   assign own_match = (key_ff == own_ff);
   assign op_known  = (op_ff == OP_LEARN) || (op_ff == OP_LOOKUP) || (op_ff == OP_FORGET)
                   || (op_ff == OP_CLEAR) || (op_ff == OP_EXPIRE);

   assign status.skip      = !op_known || ((op_ff == OP_LEARN) && own_match);
   assign status.is_learn  = (op_ff == OP_LEARN);
   assign status.scan_last = (addr_ff == LAST_IDX);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   // compare stage
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign key_match = cur_valid && (rd_dest_ff == key_ff);
   assign age       = now_ff - rd_stamp_ff;
   assign stale     = cur_valid && (age > limit_ff);

   always_comb begin
      drop = 1'b0;
      case (op_ff)
         OP_FORGET: drop = key_match;
         OP_CLEAR:  drop = cur_valid;
         OP_EXPIRE: drop = stale;
         default:   drop = 1'b0;
      endcase
   end

   // learn update
   assign wr_idx   = hit_ff ? hit_idx_ff : free_idx_ff;
   assign wr_entry = cmd.write_en && !hit_ff && free_ff;
   assign wr_stamp = cmd.write_en && (hit_ff || free_ff);
   assign wr_route = wr_entry || (cmd.write_en && hit_ff && (hops_ff <= hit_hops_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff   <= '0;
         limit_ff <= STALE_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS: own_ff   <= csr_wdata;
            CSR_STALE_LIMIT: limit_ff <= csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_operation;
         key_ff  <= req_key_mac;
         nbr_ff  <= req_neighbor_mac;
         hops_ff <= req_hop_count;
         now_ff  <= req_now_ms;
      end
   end

   // table memories
   always_ff @(posedge clock) begin
      if (wr_entry) dest_mem[wr_idx] <= key_ff;
      if (wr_route) begin
         nhop_mem[wr_idx] <= nbr_ff;
         hops_mem[wr_idx] <= hops_ff;
      end
      if (wr_stamp) stamp_mem[wr_idx] <= now_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_dest_ff  <= dest_mem[addr_ff];
         rd_nhop_ff  <= nhop_mem[addr_ff];
         rd_hops_ff  <= hops_mem[addr_ff];
         rd_stamp_ff <= stamp_mem[addr_ff];
      end
      cmp_idx_ff <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmp_vld_ff && drop) begin
         valid_ff[cmp_idx_ff] <= 1'b0;
      end else if (wr_entry) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.rd_en;
         if (cmd.scan_start) begin
            addr_ff <= '0;
         end else if (cmd.rd_en && !status.scan_last) begin
            addr_ff <= addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         removed_ff <= '0;
      end else if (cmp_vld_ff) begin
         if (key_match && !hit_ff) begin
            hit_ff      <= 1'b1;
            hit_idx_ff  <= cmp_idx_ff;
            hit_hops_ff <= rd_hops_ff;
            hit_nhop_ff <= rd_nhop_ff;
         end
         if (!cur_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= cmp_idx_ff;
         end
         if (drop) removed_ff <= removed_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_found_ff   <= 1'b0;
         rsp_nhop_ff    <= '0;
         rsp_outcome_ff <= OUT_NONE;
         rsp_removed_ff <= '0;
         case (op_ff)
            OP_LEARN: begin
               if (own_match) begin
                  rsp_outcome_ff <= OUT_OWN;
               end else if (hit_ff) begin
                  rsp_found_ff   <= 1'b1;
                  rsp_outcome_ff <= OUT_REFRESHED;
               end else if (free_ff) begin
                  rsp_outcome_ff <= OUT_INSERTED;
               end else begin
                  rsp_outcome_ff <= OUT_FULL;
               end
            end
            OP_LOOKUP: begin
               rsp_found_ff <= hit_ff;
               if (hit_ff) rsp_nhop_ff <= hit_nhop_ff;
            end
            OP_FORGET: begin
               rsp_found_ff   <= (removed_ff != '0);
               rsp_removed_ff <= removed_ff;
            end
            OP_CLEAR, OP_EXPIRE: begin
               rsp_removed_ff <= removed_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_next_hop_mac  = rsp_nhop_ff;
   assign rsp_learn_outcome = rsp_outcome_ff;
   assign rsp_removed_count = rsp_removed_ff;

endmodule

>>> hdl/mesh_route_table_aging_unit.sv
// ----------------------------------------------------------------------------
// mesh_route_table_aging_unit
// Fully associative route table keyed by station address, with learn,
// lookup, forget, clear and age-based expiry.
//
// Requests enter on req_* (valid/ready); each gives exactly one response on
// rsp_* (valid/ready). Registers own_address (index 0) and stale_limit_ms
// (index 1) are written on csr_*, which is always ready.
// Every table operation scans all TABLE_ENTRIES entries, one per cycle,
// through the single read port of the entry memories; a learn adds a
// write step after the scan. Unknown operations and learn of the own
// address skip the scan and go from the check step to the result. A new
// request is taken once the previous one has been loaded into the response
// register, even while that response is still waiting.
// Reset clears all valid bits at once, sets own_address to 0 and
// stale_limit_ms to 60000; no clearing pass is needed.
// If the receiver stalls, the response holds and the next request finishes
// its scan, then waits until the response register frees up.
// ----------------------------------------------------------------------------
module mesh_route_table_aging_unit #(
   parameter int TABLE_ENTRIES = mrta_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mrta_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mrta_pkg::CSR_DAT_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mrta_pkg::OP_W-1:0]        req_operation,
   input  logic [mrta_pkg::MAC_W-1:0]       req_key_mac,
   input  logic [mrta_pkg::MAC_W-1:0]       req_neighbor_mac,
   input  logic [mrta_pkg::HOPS_W-1:0]      req_hop_count,
   input  logic [mrta_pkg::MS_W-1:0]        req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [mrta_pkg::MAC_W-1:0]       rsp_next_hop_mac,
   output logic [mrta_pkg::OUTCOME_W-1:0]   rsp_learn_outcome,
   output logic [mrta_pkg::REMOVED_W-1:0]   rsp_removed_count
);
   import mrta_pkg::*;

   cmd_type    cmd;
   status_type status;

   mrta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mrta_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_operation     (req_operation),
      .req_key_mac       (req_key_mac),
      .req_neighbor_mac  (req_neighbor_mac),
      .req_hop_count     (req_hop_count),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_next_hop_mac  (rsp_next_hop_mac),
      .rsp_learn_outcome (rsp_learn_outcome),
      .rsp_removed_count (rsp_removed_count)
   );

endmodule
